### rtl/sbbf_pkg.sv
package sbbf_pkg;

  localparam int unsigned NUM_BLOCKS = 1024;
  localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned LANES      = 8;
  localparam int unsigned LANE_W     = 32;
  localparam int unsigned BLOCK_W    = LANES * LANE_W;
  localparam int unsigned POS_W      = $clog2(LANE_W);
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned LOG2_W     = 4;

  localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd10;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_PROBE  = 1'b1;

  localparam logic [LANE_W-1:0] SALT [LANES] = '{
    32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
    32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
  };

endpackage

### rtl/split_block_bloom_filter.sv
// Split-block Bloom filter over 1024 blocks of 256 bits, one block per RAM
// row. An item with func insert ORs an eight-bit mask (one bit in each
// 32-bit lane of the block) into the block chosen by key_hash[41:32] masked
// to 2^log2_block_count blocks; it gives no result. An item with func probe
// gives one result, maybe_present, set when every mask bit is already set.
// Lane bits come from the top five bits of key_hash[31:0] times a fixed odd
// salt per lane. Steps: accept, salt multiply and RAM read issue, then
// read-modify-write of the block row; no new item is taken until the last
// step ends; a probe waits in it while a result is held on a stalled output.
// After reset the block clears the RAM one row per cycle, all 1024 rows, and
// holds in_stall high meanwhile; configuration writes are taken at any time
// (cfg_ready is always high) but must only be issued while the block is idle.
// Values 11..15 of log2_block_count act as 10.
module split_block_bloom_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbbf_pkg::LOG2_W-1:0]       cfg_log2_block_count,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [sbbf_pkg::HASH_W-1:0]       in_key_hash,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_maybe_present
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD
  } state_t;

  localparam int unsigned IDX_W   = sbbf_pkg::IDX_W;
  localparam int unsigned BLOCK_W = sbbf_pkg::BLOCK_W;
  localparam int unsigned LANE_W  = sbbf_pkg::LANE_W;
  localparam int unsigned POS_W   = sbbf_pkg::POS_W;

  state_t                      state_r;
  logic [IDX_W-1:0]            clr_cnt_r;
  logic [sbbf_pkg::LOG2_W-1:0] log2_r;
  logic                        out_valid_r;
  logic                        out_mp_r;

  // item payload
  logic                        func_r;
  logic [IDX_W-1:0]            idx_r;
  logic [LANE_W-1:0]           low_r;
  logic [BLOCK_W-1:0]          mask_r;

  logic [IDX_W-1:0]            idx_nxt;
  logic [IDX_W-1:0]            cnt_mask;
  logic [BLOCK_W-1:0]          mask_nxt;
  logic                        in_acc;
  logic                        out_free;
  logic                        probe_done;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [BLOCK_W-1:0]          ram_wdata;
  logic                        ram_re;
  logic [BLOCK_W-1:0]          ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // block index: mask to the configured count; register >= 10 keeps all bits
  always_comb begin
    if (log2_r >= sbbf_pkg::LOG2_W'(IDX_W)) begin
      cnt_mask = '1;
    end else begin
      cnt_mask = IDX_W'((1 << log2_r) - 1);
    end
    idx_nxt = in_key_hash[LANE_W +: IDX_W] & cnt_mask;
  end

  // one salt multiplier per lane; only the top five product bits matter
  always_comb begin
    logic [LANE_W-1:0] prod;
    logic [POS_W-1:0]  pos;
    mask_nxt = '0;
    for (int l = 0; l < sbbf_pkg::LANES; l++) begin
      prod = LANE_W'(low_r * sbbf_pkg::SALT[l]);
      pos  = prod[LANE_W-1 -: POS_W];
      mask_nxt[l*LANE_W + int'(pos)] = 1'b1;
    end
  end

  // probe finishes only when the output register can take the result
  assign probe_done = (state_r == S_MOD) && (func_r == sbbf_pkg::FUNC_PROBE) && out_free;

  always_comb begin
    ram_re    = (state_r == S_HASH);
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata | mask_r;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == S_MOD && func_r == sbbf_pkg::FUNC_INSERT) begin
      ram_we = 1'b1;
    end
  end

  sbbf_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (sbbf_pkg::NUM_BLOCKS)
  ) u_blocks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      log2_r      <= sbbf_pkg::LOG2_RESET;
      out_valid_r <= 1'b0;
      out_mp_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        log2_r <= cfg_log2_block_count;
      end
      // a new result replaces one that leaves at this edge
      if (probe_done) begin
        out_valid_r <= 1'b1;
        out_mp_r    <= ((mask_r & ~ram_rdata) == '0);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          if ((func_r == sbbf_pkg::FUNC_INSERT) || probe_done) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // item payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      idx_r  <= idx_nxt;
      low_r  <= in_key_hash[LANE_W-1:0];
    end
    if (state_r == S_HASH) begin
      mask_r <= mask_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_mp_r;

endmodule

### rtl/sbbf_ram.sv
module sbbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
